/* sv/frma_pkg.sv */
// Package for the fan tachometer RPM and moving average block.
// Holds the payload types, the sequencer states, register codes and sizing
// constants shared by the top level and the divider. Depends on nothing.
`default_nettype none

package frma_pkg;

  // Build-time sizing
  localparam int WINDOW_DEPTH = 256;
  localparam int CLOCK_HZ     = 160000000;

  // Word field widths
  localparam int CAP_W   = 32;
  localparam int RPM_W   = 32;
  localparam int POLES_W = 8;
  localparam int WIN_W   = 9;

  // Ring and running sum
  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = RPM_W + $clog2(WINDOW_DEPTH);

  // Speed numerator: clock ticks per minute in Q34.8
  localparam longint RPM_NUM   = 64'(CLOCK_HZ) * 64'd60 * 64'd256;
  localparam int     RPM_NUM_W = $clog2(RPM_NUM + 64'd1);

  // Divisor is a period below 2^31 times an 8-bit pole count
  localparam int PROD_W = (CAP_W - 1) + POLES_W;

  // Divider: every quotient it produces fits in RPM_W bits
  localparam int QUO_W  = RPM_W;
  localparam int ITER_W = $clog2(QUO_W + 1);
  localparam int DVD_W  = (RPM_NUM_W > SUM_W) ? RPM_NUM_W : SUM_W;
  localparam int DVS_W  = (PROD_W > CNT_W) ? PROD_W : CNT_W;

  localparam logic [DVD_W-1:0] RPM_NUM_D = DVD_W'(RPM_NUM);
  // A divisor at or below this value gives a quotient of 2^32 or more
  localparam logic [PROD_W-1:0] SAT_DIV  = PROD_W'(RPM_NUM >> QUO_W);
  localparam logic [RPM_W-1:0]  RPM_SAT  = '1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = WIN_W;
  localparam logic [CFG_IDX_W-1:0] REG_POLES      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AVG_WINDOW = CFG_IDX_W'(1);

  localparam logic [POLES_W-1:0] POLES_RST = POLES_W'(2);
  localparam logic [WIN_W-1:0]   WIN_RST   = WIN_W'(16);

  // Input operation codes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  typedef struct packed {
    logic             op;
    logic [CAP_W-1:0] capture_value;
  } tach_in_t;

  typedef struct packed {
    logic [RPM_W-1:0] sample_rpm;
    logic [RPM_W-1:0] avg_rpm;
    logic             signal_lost;
  } tach_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_RDIV,
    S_RWAIT,
    S_RD,
    S_UPD,
    S_ADIV,
    S_AWAIT,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

/* sv/frma_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters; depends on nothing else.
`default_nettype none

module frma_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/frma_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// The caller guarantees the quotient fits in QUO_W bits. Uses frma_pkg.
`default_nettype none

module frma_div
  import frma_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [QUO_W-1:0] quot
);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] cnt_r;
  logic [DVS_W-1:0]  rem_r;
  logic [QUO_W-1:0]  quo_r;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] rem_sub;
  logic           q_bit;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    rem_sh  = {rem_r, quo_r[QUO_W-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    q_bit   = (rem_sh >= {1'b0, divisor});
  end

  // Control: busy flag, step counter, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ITER_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - ITER_W'(1);
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the high dividend part is already below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DVS_W'(dividend >> QUO_W);
      quo_r <= dividend[QUO_W-1:0];
    end else if (busy_r) begin
      rem_r <= q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], q_bit};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

/* sv/fan_tach_rpm_moving_average_core.sv */
// Fan tachometer core: capture timestamps in, speed and moving average out.
// Instantiates frma_div and frma_ram; uses frma_pkg.
`default_nettype none

// Each capture word gives a period (wrapping difference from the previous
// timestamp) that is turned into Q24.8 RPM, floor(CLOCK_HZ*60*256/(period*poles)),
// saturated to 32 bits; a timeout word reports 0 RPM with signal_lost and forgets
// the previous edge. Every reported sample enters a ring of the last avg_window
// samples held in a RAM, and the truncated mean of the held samples comes with it.
// One word is in work at a time: the next word can be accepted once the result
// of a word that reports has been loaded into the output register. The work per
// word is two passes of the shared 32-step divider (speed, then average) plus the
// multiply and the ring read-modify-write. A word that reports nothing (first
// edge, zero period) leaves the sequencer idle. Overlong periods and timeouts
// skip the multiply and the speed division; saturated speeds skip the speed
// division. The output register lets the next word be accepted while a result
// waits. Writing avg_window clears the average.

module fan_tach_rpm_moving_average_core
  import frma_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tach_in_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tach_out_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [POLES_W-1:0] poles_r;
  logic [WIN_W-1:0]   win_r;
  logic [CAP_W-1:0]   last_r;
  logic               have_last_r;
  logic [CAP_W-2:0]   period_r;
  logic [PROD_W-1:0]  prod_r;
  logic [RPM_W-1:0]   rpm_r;
  logic [RPM_W-1:0]   avg_r;
  logic               lost_r;
  logic [PTR_W-1:0]   head_r;
  logic [CNT_W-1:0]   count_r;
  logic [SUM_W-1:0]   sum_r;
  logic               out_valid_r;
  tach_out_t          out_data_r;

  logic               in_acc;
  logic [CAP_W-1:0]   period;
  logic [POLES_W-1:0] poles_eff;
  logic [CNT_W-1:0]   win_eff;
  logic [CNT_W:0]     head_ext;
  logic [CNT_W:0]     old_ext;
  logic [PTR_W-1:0]   old_addr;
  logic               ring_full;
  logic               out_load;

  logic               div_start;
  logic               div_done;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic [QUO_W-1:0]   div_quot;

  logic [RPM_W-1:0]   ram_rdata;
  logic               ram_we;

  assign in_acc = in_valid && !in_stall;
  assign period = in_data.capture_value - last_r;

  // Effective pole count and window length
  always_comb begin
    poles_eff = (poles_r == '0) ? POLES_W'(1) : poles_r;
    if (win_r == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(win_r) > 32'(WINDOW_DEPTH)) begin
      win_eff = CNT_W'(WINDOW_DEPTH);
    end else begin
      win_eff = CNT_W'(win_r);
    end
  end

  // Oldest entry in the window, wrapping around the ring
  always_comb begin
    head_ext  = (CNT_W + 1)'(head_r);
    ring_full = (count_r >= win_eff);
    if (head_ext >= (CNT_W + 1)'(win_eff)) begin
      old_ext = head_ext - (CNT_W + 1)'(win_eff);
    end else begin
      old_ext = head_ext + (CNT_W + 1)'(WINDOW_DEPTH) - (CNT_W + 1)'(win_eff);
    end
    old_addr = old_ext[PTR_W-1:0];
  end

  // Divider operands: speed pass, then average pass
  always_comb begin
    if (state_r == S_RDIV || state_r == S_RWAIT) begin
      div_dvd = RPM_NUM_D;
      div_dvs = DVS_W'(prod_r);
    end else begin
      div_dvd = DVD_W'(sum_r);
      div_dvs = DVS_W'(count_r);
    end
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.op == OP_TIMEOUT) begin
            state_nxt = S_RD;
          end else if (have_last_r && period != '0) begin
            state_nxt = period[CAP_W-1] ? S_RD : S_MUL;
          end
        end
      end
      S_MUL: state_nxt = S_RDIV;
      S_RDIV: begin
        if (prod_r <= SAT_DIV) begin
          state_nxt = S_RD;
        end else begin
          div_start = 1'b1;
          state_nxt = S_RWAIT;
        end
      end
      S_RWAIT: begin
        if (div_done) begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_UPD;
      S_UPD: begin
        ram_we    = 1'b1;
        state_nxt = S_ADIV;
      end
      S_ADIV: begin
        div_start = 1'b1;
        state_nxt = S_AWAIT;
      end
      S_AWAIT: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Edge state, ring pointers, running sum and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poles_r     <= POLES_RST;
      win_r       <= WIN_RST;
      last_r      <= '0;
      have_last_r <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
    end else begin
      if (state_r == S_IDLE && in_acc) begin
        if (in_data.op == OP_TIMEOUT) begin
          have_last_r <= 1'b0;
        end else begin
          last_r      <= in_data.capture_value;
          have_last_r <= 1'b1;
        end
      end
      if (state_r == S_UPD) begin
        sum_r <= sum_r - (ring_full ? SUM_W'(ram_rdata) : SUM_W'(0)) + SUM_W'(rpm_r);
        if (!ring_full) begin
          count_r <= count_r + CNT_W'(1);
        end
        head_r <= (head_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
      end
      if (cfg_we) begin
        if (cfg_index == REG_POLES) begin
          poles_r <= cfg_data[POLES_W-1:0];
        end else if (cfg_index == REG_AVG_WINDOW) begin
          win_r   <= cfg_data[WIN_W-1:0];
          head_r  <= '0;
          count_r <= '0;
          sum_r   <= '0;
        end
      end
    end
  end

  // Sample datapath: period, divisor product, speed, average and loss flag
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      period_r <= period[CAP_W-2:0];
      rpm_r    <= '0;
      lost_r   <= (in_data.op == OP_TIMEOUT) || period[CAP_W-1];
    end
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(period_r) * PROD_W'(poles_eff);
    end
    if (state_r == S_RDIV && prod_r <= SAT_DIV) begin
      rpm_r <= RPM_SAT;
    end
    if (state_r == S_RWAIT && div_done) begin
      rpm_r <= div_quot;
    end
    if (state_r == S_AWAIT && div_done) begin
      avg_r <= div_quot;
    end
  end

  // Output register: load the finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  // Hold the waiting word until the next one is loaded
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.sample_rpm  <= rpm_r;
      out_data_r.avg_rpm     <= avg_r;
      out_data_r.signal_lost <= lost_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  frma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot)
  );

  frma_ram #(
    .W     (RPM_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (rpm_r),
    .raddr (old_addr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

/* tb/tb_fan_tach_rpm_moving_average_core.sv */
// Testbench for fan_tach_rpm_moving_average_core: a self-checking speed and average predictor,
// directed corner words, register writes, backpressure and random traffic phases.
// Depends on frma_pkg and the core RTL only.

module tb_fan_tach_rpm_moving_average_core;
  import frma_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int LIMIT_CYCLES   = 2000000;
  localparam int RING_SLOTS     = 256;
  localparam int PHASE_WORDS    = 650;
  localparam longint unsigned SPEED_NUM = 64'(CLOCK_HZ) * 64'd60 * 64'd256;
  localparam logic [RPM_W-1:0] SPEED_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  tach_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tach_out_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  fan_tach_rpm_moving_average_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Predictor state: registers, edge tracking and the averaging ring
  logic [POLES_W-1:0] poles_setting  = POLES_RST;
  logic [WIN_W-1:0]   window_setting = WIN_RST;
  logic [CAP_W-1:0]   prev_stamp     = '0;
  bit                 prev_valid     = 1'b0;
  logic [RPM_W-1:0]   speed_ring [RING_SLOTS];
  logic [7:0]         ring_wr_ptr    = '0;
  int unsigned        ring_fill      = 0;
  longint unsigned    speed_sum      = 0;

  tach_out_t   pending_speeds [$];
  int unsigned fail_count = 0;

  // Traffic shaping knobs
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      hold_req_seq   = 0;
  logic [CAP_W-1:0] stamp          = '0;

  // Work out the result word for one accepted input word; return 0 if none
  function automatic bit compute_speed_sample(input tach_in_t w, output tach_out_t r);
    logic [CAP_W-1:0] period;
    logic [RPM_W-1:0] speed;
    longint unsigned  divisor;
    longint unsigned  quo;
    bit               lost;
    bit               had;
    int unsigned      win;
    logic [7:0]       oldest;
    r = '0;
    if (w.op == OP_TIMEOUT) begin
      prev_valid = 1'b0;
      speed = '0;
      lost = 1'b1;
    end else begin
      had = prev_valid;
      period = w.capture_value - prev_stamp;
      prev_stamp = w.capture_value;
      prev_valid = 1'b1;
      if (!had || period == '0)
        return 1'b0;
      if (period[CAP_W-1]) begin
        speed = '0;
        lost = 1'b1;
      end else begin
        divisor = 64'(period) * ((poles_setting == '0) ? 64'd1 : 64'(poles_setting));
        quo = SPEED_NUM / divisor;
        speed = (quo > 64'(SPEED_MAX)) ? SPEED_MAX : quo[RPM_W-1:0];
        lost = 1'b0;
      end
    end
    // Clamp the window, then slide the sum over the ring
    win = window_setting;
    if (win == 0)
      win = 1;
    if (win > RING_SLOTS)
      win = RING_SLOTS;
    if (ring_fill >= win) begin
      oldest = ring_wr_ptr - 8'(win);
      speed_sum -= 64'(speed_ring[oldest]);
    end else begin
      ring_fill++;
    end
    speed_sum += 64'(speed);
    speed_ring[ring_wr_ptr] = speed;
    ring_wr_ptr++;
    r.sample_rpm  = speed;
    r.avg_rpm     = RPM_W'(speed_sum / 64'(ring_fill));
    r.signal_lost = lost;
    return 1'b1;
  endfunction

  // Offer one word, hold it until accepted, then queue its expected result
  task automatic send_word(input logic op, input logic [CAP_W-1:0] cap);
    tach_in_t  w;
    tach_out_t r;
    w.op = op;
    w.capture_value = cap;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (compute_speed_sample(w, r))
      pending_speeds.push_back(r);
  endtask

  task automatic send_period(input logic [CAP_W-1:0] period);
    stamp = stamp + period;
    send_word(OP_CAPTURE, stamp);
  endtask

  // Drop valid, wait for every result, then let any silent word finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_speeds.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POLES) begin
      poles_setting = val[POLES_W-1:0];
    end else if (idx == REG_AVG_WINDOW) begin
      window_setting = val;
      ring_wr_ptr = '0;
      ring_fill = 0;
      speed_sum = 0;
    end
  endtask

  // Drive receiver stall: a long hold-off on request, else random stalls
  int unsigned hold_seen  = 0;
  int unsigned hold_count = 0;
  always @(posedge clk) begin
    if (hold_seen != hold_req_seq) begin
      hold_seen  <= hold_req_seq;
      hold_count <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_count != 0) begin
      hold_count <= hold_count - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_check
    tach_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_speeds.size() == 0) begin
        $error("result word with nothing expected: sample_rpm=%0h avg_rpm=%0h signal_lost=%0b",
               out_data.sample_rpm, out_data.avg_rpm, out_data.signal_lost);
        fail_count++;
      end else begin
        want = pending_speeds.pop_front();
        if (out_data.sample_rpm !== want.sample_rpm) begin
          $error("sample_rpm: expected %0h, got %0h", want.sample_rpm, out_data.sample_rpm);
          fail_count++;
        end
        if (out_data.avg_rpm !== want.avg_rpm) begin
          $error("avg_rpm: expected %0h, got %0h", want.avg_rpm, out_data.avg_rpm);
          fail_count++;
        end
        if (out_data.signal_lost !== want.signal_lost) begin
          $error("signal_lost: expected %0b, got %0b", want.signal_lost, out_data.signal_lost);
          fail_count++;
        end
      end
    end
  end

  // First edge, zero period, saturation, overlong periods, timeout and wrap
  task automatic test_edge_cases();
    send_word(OP_CAPTURE, 32'h0000_1000);
    send_word(OP_CAPTURE, 32'h0000_1000);
    send_word(OP_CAPTURE, 32'h0024_A000);
    send_word(OP_CAPTURE, 32'h0024_A001);
    send_word(OP_TIMEOUT, 32'hFFFF_FFFF);
    send_word(OP_CAPTURE, 32'h0000_0005);
    send_word(OP_CAPTURE, 32'h8000_0005);
    send_word(OP_CAPTURE, 32'h8000_0004);
    send_word(OP_CAPTURE, 32'hFFFF_FFF0);
    send_word(OP_CAPTURE, 32'h0000_1010);
    send_word(OP_CAPTURE, 32'h8000_100F);
    stamp = 32'h8000_100F;
  endtask

  // Pole and window extremes, bad indexes, and the clear on a window write
  task automatic test_register_writes();
    write_reg(REG_POLES, 9'h000);
    send_period(32'd1000);
    write_reg(REG_POLES, 9'h0FF);
    send_period(32'h7FFF_FFFF);
    send_period(32'd573);
    write_reg(4'h2, 9'h1FF);
    write_reg(4'hF, 9'h000);
    send_period(32'd100000);
    write_reg(REG_AVG_WINDOW, 9'd1);
    send_period(32'd200000);
    send_period(32'd300000);
    write_reg(REG_AVG_WINDOW, 9'd0);
    send_word(OP_TIMEOUT, 32'h0000_0000);
    send_period(32'd40000);
    send_period(32'd50000);
    write_reg(REG_AVG_WINDOW, 9'h1FF);
    send_period(32'd60000);
    send_period(32'd70000);
  endtask

  // Hold the receiver off so the core fills and stalls its input
  task automatic test_backpressure();
    write_reg(REG_AVG_WINDOW, 9'd4);
    write_reg(REG_POLES, 9'd2);
    send_idle_pct = 0;
    send_period(32'd120000);
    hold_req_seq++;
    repeat (8)
      send_period(32'($urandom_range(10000, 2000000)));
  endtask

  // Mostly plausible tach traffic, with timeouts, jumps and odd periods mixed in
  task automatic test_random_traffic(input int unsigned n, input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input logic [CFG_DAT_W-1:0] poles_val,
                                     input logic [CFG_DAT_W-1:0] window_val);
    int unsigned pick;
    write_reg(REG_POLES, poles_val);
    write_reg(REG_AVG_WINDOW, window_val);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_word(OP_TIMEOUT, $urandom);
      end else if (pick < 6) begin
        send_word(OP_CAPTURE, stamp);
      end else if (pick < 10) begin
        stamp = $urandom;
        send_word(OP_CAPTURE, stamp);
      end else if (pick < 15) begin
        send_period(32'($urandom_range(1, 700)));
      end else if (pick < 20) begin
        send_period(32'($urandom_range(32'h0100_0000, 32'h7FFF_FFFF)));
      end else if (pick < 23) begin
        send_period(32'h8000_0000 + 32'($urandom_range(0, 32'h7FFF_FFFF)));
      end else begin
        send_period(32'($urandom_range(20000, 5000000)));
      end
    end
  endtask

  initial begin
    send_idle_pct  = 16;
    recv_stall_pct = 59;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_cases();
    test_register_writes();
    test_backpressure();
    test_random_traffic(PHASE_WORDS, 16, 59, 9'd1, 9'd256);
    test_random_traffic(PHASE_WORDS, 59, 16, 9'd255, 9'd2);
    test_random_traffic(PHASE_WORDS, 0, 0, 9'($urandom_range(1, 255)),
                        9'($urandom_range(1, 256)));

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("Test completed with failures");
    $finish;
  end

endmodule
